/* src/bdp_pkg.sv */
// Shared constants, register indexes and controller states for the box downscaler.
`timescale 1ns / 1ps

package bdp_pkg;

   localparam int MAX_SOURCE_DEF = 512;
   localparam int MAX_TARGET_DEF = 32;

   localparam int PIX_W      = 8;
   localparam int SIZE_W     = 10;
   localparam int TSIZE_W    = 6;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 10;
   localparam int LANES      = 4;

   localparam logic [CSR_IDX_W-1:0] REG_SRC_WIDTH   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SRC_HEIGHT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TARGET_SIZE = 2'd2;

   localparam logic [SIZE_W-1:0]  SRC_WIDTH_RST   = 10'd512;
   localparam logic [SIZE_W-1:0]  SRC_HEIGHT_RST  = 10'd512;
   localparam logic [TSIZE_W-1:0] TARGET_SIZE_RST = 6'd16;

   // channel lanes inside one accumulator word
   localparam int LANE_RED   = 0;
   localparam int LANE_GREEN = 1;
   localparam int LANE_BLUE  = 2;
   localparam int LANE_ALPHA = 3;

   typedef enum logic [3:0] {
      ST_INIT_LD,
      ST_INIT,
      ST_INIT_FIN,
      ST_ACCUM,
      ST_FLUSH,
      ST_EMIT_RD,
      ST_EMIT_LD,
      ST_EMIT_DIV,
      ST_EMIT_OUT
   } state_type;

endpackage

/* src/bdp_ram.sv */
// Generic simple dual-port RAM with registered read data.
`timescale 1ns / 1ps

module bdp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

/* src/box_downscale_premultiply_core.sv */
// Top level: streaming box downscaler with premultiplied BGRA output.
`timescale 1ns / 1ps

// Usage
//   csr_*  : register writes (index 0 width, 1 height, 2 target side). Valid
//            ones restart the frame; write only while the block is idle.
//   req_*  : one RGBA source pixel per beat, raster order.
//   rsp_*  : one BGRA output pixel per beat; a full output row is sent when the
//            last source pixel of a row band has been taken.
// Throughput: one source pixel per cycle inside a band. At a band end the
//   input stalls while the row is produced: per output pixel a read state, a
//   load state, the shared restoring divider and an output state, after a
//   single flush state.
// Reset and every restart run a setup pass (accumulator RAM clear, bin step
//   division) with req_ready low.
// A stalled receiver holds the output register; the row sequencer waits on it.
module box_downscale_premultiply_core #(
   parameter int MAX_SOURCE = bdp_pkg::MAX_SOURCE_DEF,
   parameter int MAX_TARGET = bdp_pkg::MAX_TARGET_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [bdp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bdp_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [bdp_pkg::PIX_W-1:0]      req_red,
   input  logic [bdp_pkg::PIX_W-1:0]      req_green,
   input  logic [bdp_pkg::PIX_W-1:0]      req_blue,
   input  logic [bdp_pkg::PIX_W-1:0]      req_alpha,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [bdp_pkg::PIX_W-1:0]      rsp_out_blue,
   output logic [bdp_pkg::PIX_W-1:0]      rsp_out_green,
   output logic [bdp_pkg::PIX_W-1:0]      rsp_out_red,
   output logic [bdp_pkg::PIX_W-1:0]      rsp_out_alpha,
   output logic                           rsp_row_done,
   output logic                           rsp_frame_done
);

   localparam int DIM_W  = $clog2(MAX_SOURCE + 1);
   localparam int TGT_W  = $clog2(MAX_TARGET + 1);
   localparam int CI_W   = (MAX_TARGET > 1) ? $clog2(MAX_TARGET) : 1;
   localparam int CNT_W  = $clog2(MAX_SOURCE * MAX_SOURCE + 1);
   localparam int ACC_W  = $clog2(longint'(255) * MAX_SOURCE * MAX_SOURCE + 1);
   localparam int DCNT_W = $clog2(ACC_W + 1);
   localparam int LANES  = bdp_pkg::LANES;
   localparam int PIX_W  = bdp_pkg::PIX_W;

   function automatic logic [PIX_W-1:0] div255(input logic [2*PIX_W-1:0] x);
      logic [2*PIX_W:0] s;
      s = (2*PIX_W+1)'(x) + (2*PIX_W+1)'(x >> PIX_W) + (2*PIX_W+1)'(1);
      return PIX_W'(s >> PIX_W);
   endfunction

   // configuration
   logic [bdp_pkg::SIZE_W-1:0]  cfg_width_ff, cfg_height_ff;
   logic [bdp_pkg::TSIZE_W-1:0] cfg_target_ff;
   logic                        csr_hit;

   bdp_pkg::state_type state_ff, state_in;

   logic [DIM_W-1:0] w_eff, h_eff;
   logic [TGT_W-1:0] t_eff;
   logic [DIM_W-1:0] eff_w_ff, eff_h_ff;
   logic [TGT_W-1:0] eff_t_ff;
   logic [DIM_W-1:0] qw_ff, qh_ff;
   logic [TGT_W-1:0] rw_ff, rh_ff;

   // source position and bin trackers
   logic [DIM_W-1:0] src_col_ff, src_row_ff;
   logic [CI_W-1:0]  bin_col_ff;
   logic [DIM_W-1:0] col_end_ff, row_start_ff, row_end_ff;
   logic [TGT_W-1:0] col_rem_ff, row_rem_ff;
   logic [DIM_W-1:0] band_rows_ff;
   logic             last_band_ff;

   // accumulate pipeline
   logic                            p_vld_ff, f_vld_ff;
   logic [CI_W-1:0]                 p_addr_ff, f_addr_ff;
   logic [LANES-1:0][PIX_W-1:0]     p_pix_ff;
   logic [LANES-1:0][ACC_W-1:0]     f_data_ff, acc_base, acc_sum;

   // RAM
   logic                        ram_we;
   logic [CI_W-1:0]             ram_waddr, ram_raddr;
   logic [LANES-1:0][ACC_W-1:0] ram_wdata, ram_rdata;
   logic [CI_W-1:0]             clr_addr_ff;
   logic                        clr_done_ff;

   // divider
   logic [LANES-1:0][ACC_W-1:0] div_q_ff, div_q_nx;
   logic [LANES-1:0][CNT_W-1:0] div_r_ff, div_r_nx;
   logic [CNT_W-1:0]            div_d_ff;
   logic [DCNT_W-1:0]           div_cnt_ff;
   logic [CNT_W:0]              div_sh;

   // emission
   logic [TGT_W-1:0] em_col_ff;
   logic [DIM_W-1:0] em_xs_ff, em_xe_ff;
   logic [TGT_W-1:0] em_rem_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             em_last, rsp_load;

   logic             rsp_valid_ff, rsp_row_done_ff, rsp_frame_done_ff;
   logic [PIX_W-1:0] rsp_blue_ff, rsp_green_ff, rsp_red_ff, rsp_alpha_ff;

   // tracker steps
   logic [TGT_W:0]   col_sum, row_sum, em_sum;
   logic             col_wrap, row_wrap, em_wrap;
   logic [DIM_W-1:0] col_end_nx, row_end_nx, em_xe_nx;
   logic [TGT_W-1:0] col_rem_nx, row_rem_nx, em_rem_nx;

   logic             req_acc;
   logic [DIM_W-1:0] src_col_nx, src_row_nx;
   logic             row_last, band_end, band_last;

   logic [2*DIM_W-1:0] area;
   logic [PIX_W-1:0]   mean_a;

   assign csr_ready = 1'b1;
   assign csr_hit   = csr_valid && (csr_index == bdp_pkg::REG_SRC_WIDTH ||
                                    csr_index == bdp_pkg::REG_SRC_HEIGHT ||
                                    csr_index == bdp_pkg::REG_TARGET_SIZE);

   assign req_ready = (state_ff == bdp_pkg::ST_ACCUM);
   assign req_acc   = req_valid && req_ready;

   // effective sizes
   always_comb begin
      if (cfg_width_ff == '0) begin
         w_eff = DIM_W'(1);
      end else if (32'(cfg_width_ff) > 32'(MAX_SOURCE)) begin
         w_eff = DIM_W'(MAX_SOURCE);
      end else begin
         w_eff = DIM_W'(cfg_width_ff);
      end
      if (cfg_height_ff == '0) begin
         h_eff = DIM_W'(1);
      end else if (32'(cfg_height_ff) > 32'(MAX_SOURCE)) begin
         h_eff = DIM_W'(MAX_SOURCE);
      end else begin
         h_eff = DIM_W'(cfg_height_ff);
      end
      if (cfg_target_ff == '0) begin
         t_eff = TGT_W'(1);
      end else if (32'(cfg_target_ff) > 32'(MAX_TARGET)) begin
         t_eff = TGT_W'(MAX_TARGET);
      end else begin
         t_eff = TGT_W'(cfg_target_ff);
      end
      if (32'(t_eff) > 32'(w_eff)) begin
         t_eff = TGT_W'(w_eff);
      end
      if (32'(t_eff) > 32'(h_eff)) begin
         t_eff = TGT_W'(h_eff);
      end
   end

   // bin edge i*N/T tracked as quotient plus remainder, one add per step
   always_comb begin
      col_sum    = (TGT_W+1)'(col_rem_ff) + (TGT_W+1)'(rw_ff);
      col_wrap   = col_sum >= (TGT_W+1)'(eff_t_ff);
      col_end_nx = col_end_ff + qw_ff + DIM_W'(col_wrap);
      col_rem_nx = col_wrap ? TGT_W'(col_sum - (TGT_W+1)'(eff_t_ff)) : TGT_W'(col_sum);

      row_sum    = (TGT_W+1)'(row_rem_ff) + (TGT_W+1)'(rh_ff);
      row_wrap   = row_sum >= (TGT_W+1)'(eff_t_ff);
      row_end_nx = row_end_ff + qh_ff + DIM_W'(row_wrap);
      row_rem_nx = row_wrap ? TGT_W'(row_sum - (TGT_W+1)'(eff_t_ff)) : TGT_W'(row_sum);

      em_sum     = (TGT_W+1)'(em_rem_ff) + (TGT_W+1)'(rw_ff);
      em_wrap    = em_sum >= (TGT_W+1)'(eff_t_ff);
      em_xe_nx   = em_xe_ff + qw_ff + DIM_W'(em_wrap);
      em_rem_nx  = em_wrap ? TGT_W'(em_sum - (TGT_W+1)'(eff_t_ff)) : TGT_W'(em_sum);
   end

   assign src_col_nx = src_col_ff + DIM_W'(1);
   assign src_row_nx = src_row_ff + DIM_W'(1);
   assign row_last   = (src_col_nx == eff_w_ff);
   assign band_end   = row_last && (src_row_nx >= row_end_ff);
   assign band_last  = (src_row_nx >= eff_h_ff);

   assign em_last  = ((TGT_W+1)'(em_col_ff) + (TGT_W+1)'(1)) == (TGT_W+1)'(eff_t_ff);
   assign rsp_load = (state_ff == bdp_pkg::ST_EMIT_OUT) && (!rsp_valid_ff || rsp_ready);
   assign area     = (2*DIM_W)'(em_xe_ff - em_xs_ff) * (2*DIM_W)'(band_rows_ff);
   assign mean_a   = div_q_ff[bdp_pkg::LANE_ALPHA][PIX_W-1:0];

   // read-modify-write with forwarding of the previous cycle's write
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         acc_base[i] = (f_vld_ff && f_addr_ff == p_addr_ff) ? f_data_ff[i] : ram_rdata[i];
         acc_sum[i]  = acc_base[i] + ACC_W'(p_pix_ff[i]);
      end
   end

   // restoring divider, four lanes sharing one divisor
   always_comb begin
      div_sh = '0;
      for (int i = 0; i < LANES; i++) begin
         div_sh = {div_r_ff[i], div_q_ff[i][ACC_W-1]};
         if (div_sh >= {1'b0, div_d_ff}) begin
            div_r_nx[i] = CNT_W'(div_sh - {1'b0, div_d_ff});
            div_q_nx[i] = {div_q_ff[i][ACC_W-2:0], 1'b1};
         end else begin
            div_r_nx[i] = CNT_W'(div_sh);
            div_q_nx[i] = {div_q_ff[i][ACC_W-2:0], 1'b0};
         end
      end
   end

   // next state and RAM port control
   always_comb begin
      state_in  = state_ff;
      ram_we    = 1'b0;
      ram_waddr = p_addr_ff;
      ram_wdata = acc_sum;
      ram_raddr = bin_col_ff;
      if (p_vld_ff) begin
         ram_we = 1'b1;
      end
      unique case (state_ff)
         bdp_pkg::ST_INIT_LD: begin
            state_in = bdp_pkg::ST_INIT;
         end
         bdp_pkg::ST_INIT: begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_ff;
            ram_wdata = '0;
            if (clr_done_ff && div_cnt_ff == '0) begin
               state_in = bdp_pkg::ST_INIT_FIN;
            end
         end
         bdp_pkg::ST_INIT_FIN: begin
            state_in = bdp_pkg::ST_ACCUM;
         end
         bdp_pkg::ST_ACCUM: begin
            if (req_acc && band_end) begin
               state_in = bdp_pkg::ST_FLUSH;
            end
         end
         bdp_pkg::ST_FLUSH: begin
            state_in = bdp_pkg::ST_EMIT_RD;
         end
         bdp_pkg::ST_EMIT_RD: begin
            ram_raddr = em_col_ff[CI_W-1:0];
            state_in  = bdp_pkg::ST_EMIT_LD;
         end
         bdp_pkg::ST_EMIT_LD: begin
            // column is consumed: clear it for the next band
            ram_we    = 1'b1;
            ram_waddr = em_col_ff[CI_W-1:0];
            ram_wdata = '0;
            state_in  = bdp_pkg::ST_EMIT_DIV;
         end
         bdp_pkg::ST_EMIT_DIV: begin
            if (div_cnt_ff == '0) begin
               state_in = bdp_pkg::ST_EMIT_OUT;
            end
         end
         bdp_pkg::ST_EMIT_OUT: begin
            if (rsp_load) begin
               state_in = em_last ? bdp_pkg::ST_ACCUM : bdp_pkg::ST_EMIT_RD;
            end
         end
         default: begin
            state_in = bdp_pkg::ST_INIT_LD;
         end
      endcase
      if (csr_hit) begin
         state_in = bdp_pkg::ST_INIT_LD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bdp_pkg::ST_INIT_LD;
      end else begin
         state_ff <= state_in;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_width_ff  <= bdp_pkg::SRC_WIDTH_RST;
         cfg_height_ff <= bdp_pkg::SRC_HEIGHT_RST;
         cfg_target_ff <= bdp_pkg::TARGET_SIZE_RST;
         p_vld_ff      <= 1'b0;
         f_vld_ff      <= 1'b0;
         div_cnt_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               bdp_pkg::REG_SRC_WIDTH:   cfg_width_ff  <= csr_wdata;
               bdp_pkg::REG_SRC_HEIGHT:  cfg_height_ff <= csr_wdata;
               bdp_pkg::REG_TARGET_SIZE: cfg_target_ff <= bdp_pkg::TSIZE_W'(csr_wdata);
               default: ;
            endcase
         end
         p_vld_ff <= req_acc && !csr_hit;
         f_vld_ff <= p_vld_ff;
         if (state_ff == bdp_pkg::ST_INIT_LD || state_ff == bdp_pkg::ST_EMIT_LD) begin
            div_cnt_ff <= DCNT_W'(ACC_W);
         end else if (div_cnt_ff != '0) begin
            div_cnt_ff <= div_cnt_ff - DCNT_W'(1);
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      p_addr_ff <= bin_col_ff;
      p_pix_ff  <= {req_alpha, req_blue, req_green, req_red};
      f_addr_ff <= p_addr_ff;
      f_data_ff <= acc_sum;

      if (div_cnt_ff != '0) begin
         div_q_ff <= div_q_nx;
         div_r_ff <= div_r_nx;
      end

      unique case (state_ff)
         bdp_pkg::ST_INIT_LD: begin
            eff_w_ff    <= w_eff;
            eff_h_ff    <= h_eff;
            eff_t_ff    <= t_eff;
            clr_addr_ff <= '0;
            clr_done_ff <= 1'b0;
            div_q_ff    <= '0;
            div_r_ff    <= '0;
            div_q_ff[0] <= ACC_W'(w_eff);
            div_q_ff[1] <= ACC_W'(h_eff);
            div_d_ff    <= CNT_W'(t_eff);
         end
         bdp_pkg::ST_INIT: begin
            if (clr_addr_ff == CI_W'(MAX_TARGET - 1)) begin
               clr_done_ff <= 1'b1;
            end else begin
               clr_addr_ff <= clr_addr_ff + CI_W'(1);
            end
         end
         bdp_pkg::ST_INIT_FIN: begin
            qw_ff        <= DIM_W'(div_q_ff[0]);
            rw_ff        <= TGT_W'(div_r_ff[0]);
            qh_ff        <= DIM_W'(div_q_ff[1]);
            rh_ff        <= TGT_W'(div_r_ff[1]);
            src_col_ff   <= '0;
            src_row_ff   <= '0;
            bin_col_ff   <= '0;
            col_end_ff   <= DIM_W'(div_q_ff[0]);
            col_rem_ff   <= TGT_W'(div_r_ff[0]);
            row_start_ff <= '0;
            row_end_ff   <= DIM_W'(div_q_ff[1]);
            row_rem_ff   <= TGT_W'(div_r_ff[1]);
         end
         bdp_pkg::ST_ACCUM: begin
            if (req_acc) begin
               if (row_last) begin
                  src_col_ff <= '0;
                  bin_col_ff <= '0;
                  col_end_ff <= qw_ff;
                  col_rem_ff <= rw_ff;
                  if (band_end) begin
                     band_rows_ff <= row_end_ff - row_start_ff;
                     last_band_ff <= band_last;
                     if (band_last) begin
                        src_row_ff   <= '0;
                        row_start_ff <= '0;
                        row_end_ff   <= qh_ff;
                        row_rem_ff   <= rh_ff;
                     end else begin
                        src_row_ff   <= src_row_nx;
                        row_start_ff <= row_end_ff;
                        row_end_ff   <= row_end_nx;
                        row_rem_ff   <= row_rem_nx;
                     end
                  end else begin
                     src_row_ff <= src_row_nx;
                  end
               end else begin
                  src_col_ff <= src_col_nx;
                  if (src_col_nx >= col_end_ff) begin
                     bin_col_ff <= bin_col_ff + CI_W'(1);
                     col_end_ff <= col_end_nx;
                     col_rem_ff <= col_rem_nx;
                  end
               end
            end
         end
         bdp_pkg::ST_FLUSH: begin
            em_col_ff <= '0;
            em_xs_ff  <= '0;
            em_xe_ff  <= qw_ff;
            em_rem_ff <= rw_ff;
         end
         bdp_pkg::ST_EMIT_RD: begin
            cnt_ff <= CNT_W'(area);
         end
         bdp_pkg::ST_EMIT_LD: begin
            div_q_ff <= ram_rdata;
            div_r_ff <= '0;
            div_d_ff <= (cnt_ff == '0) ? CNT_W'(1) : cnt_ff;
         end
         bdp_pkg::ST_EMIT_DIV: ;
         bdp_pkg::ST_EMIT_OUT: begin
            if (rsp_load) begin
               rsp_alpha_ff      <= mean_a;
               rsp_red_ff        <= div255(
                  (2*PIX_W)'(div_q_ff[bdp_pkg::LANE_RED][PIX_W-1:0]) * (2*PIX_W)'(mean_a));
               rsp_green_ff      <= div255(
                  (2*PIX_W)'(div_q_ff[bdp_pkg::LANE_GREEN][PIX_W-1:0]) * (2*PIX_W)'(mean_a));
               rsp_blue_ff       <= div255(
                  (2*PIX_W)'(div_q_ff[bdp_pkg::LANE_BLUE][PIX_W-1:0]) * (2*PIX_W)'(mean_a));
               rsp_row_done_ff   <= em_last;
               rsp_frame_done_ff <= em_last && last_band_ff;
               em_col_ff         <= em_col_ff + TGT_W'(1);
               em_xs_ff          <= em_xe_ff;
               em_xe_ff          <= em_xe_nx;
               em_rem_ff         <= em_rem_nx;
            end
         end
         default: ;
      endcase
   end

   bdp_ram #(
      .WIDTH (LANES * ACC_W),
      .DEPTH (MAX_TARGET),
      .AW    (CI_W)
   ) u_acc_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_blue   = rsp_blue_ff;
   assign rsp_out_green  = rsp_green_ff;
   assign rsp_out_red    = rsp_red_ff;
   assign rsp_out_alpha  = rsp_alpha_ff;
   assign rsp_row_done   = rsp_row_done_ff;
   assign rsp_frame_done = rsp_frame_done_ff;

`ifndef SYNTH
   a_frame_ends_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_frame_done_ff |-> rsp_row_done_ff)
      else $error("frame end without row end");

   a_flushed_before_emit: assert property (@(posedge clock) disable iff (reset)
      state_ff == bdp_pkg::ST_EMIT_RD |-> !p_vld_ff)
      else $error("accumulate write pending while reading a column");

   a_bin_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == bdp_pkg::ST_ACCUM |-> (TGT_W)'(bin_col_ff) < eff_t_ff)
      else $error("column bin beyond target size");

   a_div_done_on_out: assert property (@(posedge clock) disable iff (reset)
      state_ff == bdp_pkg::ST_EMIT_OUT |-> div_cnt_ff == '0)
      else $error("output taken before division finished");
`endif

endmodule
